// ===== rtl/core/psts_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// psts_pkg: shared types and constants
// Table geometry, station entry layout, result record layout and the
// controller state encoding of the per-source traffic statistics table.
// ---------------------------------------------------------------------------
package psts_pkg;

	// station table geometry
	localparam int TABLE_ENTRIES = 32;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	// field widths
	localparam int ADDR_W = 48;
	localparam int WORD_W = 32;
	localparam int SIG_W  = 8;
	localparam int LEN_W  = 12;
	localparam int TOT_W  = 6;

	// window reset values
	localparam logic signed [SIG_W-1:0] MAX_FLOOR     = -8'sd127;
	localparam logic signed [SIG_W-1:0] THRESH_RESET  = -8'sd60;

	// frame type codes
	localparam logic [1:0] FT_MGMT    = 2'd0;
	localparam logic [1:0] FT_DATA    = 2'd1;
	localparam logic [1:0] FT_CONTROL = 2'd2;
	localparam logic [1:0] FT_OTHER   = 2'd3;

	// command and record kind codes
	localparam logic CMD_FRAME   = 1'b0;
	localparam logic CMD_CLOSE   = 1'b1;
	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_STATION = 1'b1;

	// one station entry in the table memory
	typedef struct packed {
		logic [ADDR_W-1:0]        addr;
		logic [WORD_W-1:0]        packets;
		logic [WORD_W-1:0]        bytes;
		logic signed [WORD_W-1:0] sig_sum;
	} entry_t;

	// result record as it sits in the output tdata, first field highest
	typedef struct packed {
		logic [1:0]               pad;
		logic [TOT_W-1:0]         station_total;
		logic [WORD_W-1:0]        overflow_bytes;
		logic [WORD_W-1:0]        overflow_packets;
		logic signed [SIG_W-1:0]  signal_min;
		logic signed [SIG_W-1:0]  signal_max;
		logic [WORD_W-1:0]        strong_count;
		logic signed [WORD_W-1:0] signal_sum;
		logic [WORD_W-1:0]        byte_count;
		logic [WORD_W-1:0]        packet_count;
		logic [ADDR_W-1:0]        station_address;
	} out_rec_t;

	// controller states
	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_SEARCH  = 5'b00010,
		ST_SUMMARY = 5'b00100,
		ST_DUMP_RD = 5'b01000,
		ST_DUMP_WR = 5'b10000
	} state_t;

endpackage

// ===== rtl/core/per_source_traffic_stats_table.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// per_source_traffic_stats_table: per-station traffic statistics window
// Collects window totals and per-source counters in a station table memory
// and reports them as a stream of records on a close-window command.
// ---------------------------------------------------------------------------
// Usage:
// - s_* carries one transaction per received frame or close command.
//   s_tuser = {frame_type, command}; s_tdata = {source_address,
//   frame_length, signal_dbm}, last field in the lowest bits.
// - m_* carries result records; m_tuser is the record kind, m_tlast marks
//   the final record of a report.
// - cfg_* writes the strong-signal threshold; cfg_ready is always high.
// - A management or data frame is searched in the station table memory,
//   one entry read per cycle with the compare in the cycle after the read,
//   until a hit or the last stored station; a miss inserts the station or,
//   with the table full, counts the frame as overflow. Control frames and
//   ignored frames are not searched. The table has a single read port.
// - A close command gives one summary record, then one record per stored
//   station in insertion order, each read from the table and then loaded
//   into the output register. The window is cleared with the last one.
// - If the receiver stalls, the output register holds its record and the
//   report waits; no input is taken until the report is done.
// - Reset clears the window counters and sets the threshold to -60; the
//   table contents are left as they are and read only after being written.
// ---------------------------------------------------------------------------
module per_source_traffic_stats_table (
	input  logic         clk,
	input  logic         arst_n,
	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,   // signal_dbm, frame_length, source_address, zero pad
	input  logic [2:0]   s_tuser,   // command, frame_type
	// output stream
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [263:0] m_tdata,   // station_address, packet_count, byte_count,
	                                // signal_sum, strong_count, signal_max, signal_min,
	                                // overflow_packets, overflow_bytes, station_total, pad
	output logic         m_tuser,   // record_kind
	output logic         m_tlast,
	// threshold register write
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_data
);

	localparam int IW = psts_pkg::IDX_W;
	localparam int CW = psts_pkg::CNT_W;
	localparam int WW = psts_pkg::WORD_W;
	localparam int SW = psts_pkg::SIG_W;

	// input field unpacking
	logic                          in_cmd;
	logic [1:0]                    in_ftype;
	logic signed [SW-1:0]          in_sig;
	logic [psts_pkg::LEN_W-1:0]    in_len;
	logic [psts_pkg::ADDR_W-1:0]   in_addr;

	assign in_cmd   = s_tuser[0];
	assign in_ftype = s_tuser[2:1];
	assign in_sig   = s_tdata[7:0];
	assign in_len   = s_tdata[19:8];
	assign in_addr  = s_tdata[67:20];

	// state and registers
	psts_pkg::state_t              state_q, state_d;
	logic signed [SW-1:0]          thr_q;
	logic signed [SW-1:0]          sig_q;
	logic [psts_pkg::LEN_W-1:0]    len_q;
	logic [psts_pkg::ADDR_W-1:0]   addr_q;
	logic [WW-1:0]                 win_pk_q, win_by_q, win_strong_q;
	logic signed [WW-1:0]          win_sum_q;
	logic signed [SW-1:0]          win_max_q, win_min_q;
	logic [CW-1:0]                 stored_q;
	logic [WW-1:0]                 spill_pk_q, spill_by_q;
	logic [CW-1:0]                 idx_q;
	logic                          rd_valid_s1;
	logic [IW-1:0]                 rd_idx_s1;
	psts_pkg::entry_t              rdata_s1;
	psts_pkg::out_rec_t            out_q;
	logic                          out_valid_q, out_kind_q, out_last_q;

	// station table memory
	psts_pkg::entry_t              mem [psts_pkg::TABLE_ENTRIES];

	// control
	logic                          s_acc;
	logic                          out_free;
	logic                          rd_en;
	logic [IW-1:0]                 rd_addr;
	logic                          hit;
	logic                          miss_done;
	logic                          mem_we;
	logic [IW-1:0]                 mem_waddr;
	psts_pkg::entry_t              mem_wdata;
	logic                          do_insert;
	logic                          do_spill;
	logic                          load_sum;
	logic                          load_st;
	logic                          st_last;
	logic                          clear_win;
	logic                          win_upd;
	logic signed [WW-1:0]          in_sig_ext;
	logic signed [WW-1:0]          sig_q_ext;
	logic [WW-1:0]                 len_q_ext;

	assign s_tready  = (state_q == psts_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign s_acc     = s_tvalid & s_tready;
	assign out_free  = ~out_valid_q | m_tready;

	assign in_sig_ext = WW'(in_sig);
	assign sig_q_ext  = WW'(sig_q);
	assign len_q_ext  = WW'(len_q);

	assign win_upd = s_acc && (in_cmd == psts_pkg::CMD_FRAME)
		&& (in_ftype != psts_pkg::FT_OTHER);

	// search compare, in the cycle after the read
	assign hit = rd_valid_s1 && (rdata_s1.addr == addr_q);
	assign miss_done = (stored_q == '0)
		|| (rd_valid_s1 && !hit && (CW'(rd_idx_s1) == stored_q - CW'(1)));
	assign st_last = (idx_q == stored_q - CW'(1));

	// next state and datapath control
	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = idx_q[IW-1:0];
		mem_we    = 1'b0;
		mem_waddr = rd_idx_s1;
		mem_wdata = '{addr: addr_q, packets: rdata_s1.packets + WW'(1),
			bytes: rdata_s1.bytes + len_q_ext, sig_sum: rdata_s1.sig_sum + sig_q_ext};
		do_insert = 1'b0;
		do_spill  = 1'b0;
		load_sum  = 1'b0;
		load_st   = 1'b0;
		clear_win = 1'b0;
		unique case (state_q)
			psts_pkg::ST_IDLE: begin
				if (s_acc) begin
					if (in_cmd == psts_pkg::CMD_CLOSE) begin
						state_d = psts_pkg::ST_SUMMARY;
					end else if (in_ftype == psts_pkg::FT_MGMT
						|| in_ftype == psts_pkg::FT_DATA) begin
						state_d = psts_pkg::ST_SEARCH;
					end
				end
			end
			psts_pkg::ST_SEARCH: begin
				if (hit) begin
					mem_we  = 1'b1;
					state_d = psts_pkg::ST_IDLE;
				end else if (miss_done) begin
					if (stored_q < CW'(psts_pkg::TABLE_ENTRIES)) begin
						do_insert = 1'b1;
						mem_we    = 1'b1;
						mem_waddr = stored_q[IW-1:0];
						mem_wdata = '{addr: addr_q, packets: WW'(1), bytes: len_q_ext,
							sig_sum: sig_q_ext};
					end else begin
						do_spill = 1'b1;
					end
					state_d = psts_pkg::ST_IDLE;
				end else begin
					rd_en = (idx_q < stored_q);
				end
			end
			psts_pkg::ST_SUMMARY: begin
				if (out_free) begin
					load_sum = 1'b1;
					if (stored_q == '0) begin
						clear_win = 1'b1;
						state_d   = psts_pkg::ST_IDLE;
					end else begin
						state_d = psts_pkg::ST_DUMP_RD;
					end
				end
			end
			psts_pkg::ST_DUMP_RD: begin
				rd_en   = 1'b1;
				state_d = psts_pkg::ST_DUMP_WR;
			end
			psts_pkg::ST_DUMP_WR: begin
				if (out_free) begin
					load_st = 1'b1;
					if (st_last) begin
						clear_win = 1'b1;
						state_d   = psts_pkg::ST_IDLE;
					end else begin
						state_d = psts_pkg::ST_DUMP_RD;
					end
				end
			end
			default: state_d = psts_pkg::ST_IDLE;
		endcase
	end

	// table memory, synchronous read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// frame fields captured at acceptance
	always_ff @(posedge clk) begin
		if (s_acc) begin
			sig_q   <= in_sig;
			len_q   <= in_len;
			addr_q  <= in_addr;
		end
		if (rd_en) begin
			rd_idx_s1 <= rd_addr;
		end
	end

	// control state, window totals and table bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= psts_pkg::ST_IDLE;
			thr_q        <= psts_pkg::THRESH_RESET;
			win_pk_q     <= '0;
			win_by_q     <= '0;
			win_strong_q <= '0;
			win_sum_q    <= '0;
			win_max_q    <= psts_pkg::MAX_FLOOR;
			win_min_q    <= '0;
			stored_q     <= '0;
			spill_pk_q   <= '0;
			spill_by_q   <= '0;
			idx_q        <= '0;
			rd_valid_s1  <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_en && (state_q == psts_pkg::ST_SEARCH);
			if (cfg_valid) begin
				thr_q <= cfg_data;
			end
			// window totals on every counted frame
			if (win_upd) begin
				win_pk_q  <= win_pk_q + WW'(1);
				win_by_q  <= win_by_q + WW'(in_len);
				win_sum_q <= win_sum_q + in_sig_ext;
				if (in_sig > thr_q) begin
					win_strong_q <= win_strong_q + WW'(1);
				end
				if (in_sig > win_max_q) begin
					win_max_q <= in_sig;
				end
				if (win_min_q == '0 || in_sig < win_min_q) begin
					win_min_q <= in_sig;
				end
			end
			// read index for search and report
			if (s_acc || load_sum) begin
				idx_q <= '0;
			end else if (rd_en && state_q == psts_pkg::ST_SEARCH) begin
				idx_q <= idx_q + CW'(1);
			end else if (load_st) begin
				idx_q <= idx_q + CW'(1);
			end
			if (do_insert) begin
				stored_q <= stored_q + CW'(1);
			end
			if (do_spill) begin
				spill_pk_q <= spill_pk_q + WW'(1);
				spill_by_q <= spill_by_q + len_q_ext;
			end
			// window clear after the last record of a report
			if (clear_win) begin
				win_pk_q     <= '0;
				win_by_q     <= '0;
				win_strong_q <= '0;
				win_sum_q    <= '0;
				win_max_q    <= psts_pkg::MAX_FLOOR;
				win_min_q    <= '0;
				stored_q     <= '0;
				spill_pk_q   <= '0;
				spill_by_q   <= '0;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_sum || load_st) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output record payload
	always_ff @(posedge clk) begin
		if (load_sum) begin
			out_kind_q <= psts_pkg::KIND_SUMMARY;
			out_last_q <= (stored_q == '0);
			out_q      <= '{pad: 2'b00,
				station_total: psts_pkg::TOT_W'(stored_q),
				overflow_bytes: spill_by_q, overflow_packets: spill_pk_q,
				signal_min: win_min_q, signal_max: win_max_q,
				strong_count: win_strong_q, signal_sum: win_sum_q,
				byte_count: win_by_q, packet_count: win_pk_q,
				station_address: '0};
		end else if (load_st) begin
			out_kind_q <= psts_pkg::KIND_STATION;
			out_last_q <= st_last;
			out_q      <= '{pad: 2'b00, station_total: '0,
				overflow_bytes: '0, overflow_packets: '0,
				signal_min: '0, signal_max: '0, strong_count: '0,
				signal_sum: rdata_s1.sig_sum, byte_count: rdata_s1.bytes,
				packet_count: rdata_s1.packets, station_address: rdata_s1.addr};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	// the table never holds more stations than it has entries
	assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= CW'(psts_pkg::TABLE_ENTRIES))
		else $error("station count beyond table size");

	// the table is written only while a frame is being looked up
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == psts_pkg::ST_SEARCH))
		else $error("table write outside search");

	// a close command always starts a report with the summary record
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && in_cmd == psts_pkg::CMD_CLOSE) |=> (state_q == psts_pkg::ST_SUMMARY))
		else $error("close command did not start a report");

	// a new record is never loaded over one that the receiver has not taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !(load_sum || load_st))
		else $error("output record overwritten");

endmodule
